>>> design/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg
// shared constants, config struct and sine table builder for the drive mixer
// ----------------------------------------------------------------------------
package cdm_pkg;

    // quarter-wave sine table size (table holds one extra end entry)
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int SINE_POS_W         = 16 + SINE_IDX_W;

    // field widths
    localparam int IN_W   = 16;
    localparam int DB_W   = 17;
    localparam int OUT_W  = 17;
    localparam int THR_W  = 14;
    localparam int GAIN_W = 16;

    // q1.15 one
    localparam logic [15:0] Q15_ONE = 16'h8000;

    // pipeline depths
    localparam int DB_LAT    = 3;
    localparam int SHAPE_LAT = 5;
    localparam int LATENCY   = DB_LAT + 2 * SHAPE_LAT + 3;

    // config register map, selected by paddr[2]
    localparam int   APB_ADDR_W    = 3;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_GAIN      = 1'b1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 14'd2458;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd35425;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [GAIN_W-1:0] gain;
    } cdm_cfg_t;

    typedef logic [15:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

    // pi/2 in q2.30 and the taylor series divisors (2k)(2k+1)
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [7:0]  TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                 8'd110, 8'd156, 8'd210};

    // sin(th), th q2.30 in [0, pi/2], result q1.15 rounded half up
    function automatic logic [15:0] taylor_sin_q15(input logic [63:0] th);
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        th2  = (th * th) >> 30;
        term = th;
        sum  = signed'(th);
        for (k = 1; k <= 7; k++)
        begin
            term = (term * th2) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768)
            sum = 64'sd32768;
        return sum[15:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        int        i;
        for (i = 0; i <= SINE_TABLE_ENTRIES; i++)
        begin
            tab[i] = taylor_sin_q15((PI_HALF_Q30 * 64'(i)) / SINE_TABLE_ENTRIES);
        end
        return tab;
    endfunction

endpackage

>>> design/cdm_apb_regs.sv
// ----------------------------------------------------------------------------
// cdm_apb_regs
// apb register file holding the deadband threshold and rescale gain
// ----------------------------------------------------------------------------
module cdm_apb_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output cdm_pkg::cdm_cfg_t              cfg
);
    import cdm_pkg::*;

    logic [THR_W-1:0]  threshold_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              wr_en;

    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            gain_reg      <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_THRESHOLD)
                threshold_reg <= pwdata[THR_W-1:0];
            else
                gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_THRESHOLD)
            prdata = {{(32-THR_W){1'b0}}, threshold_reg};
        else
            prdata = {{(32-GAIN_W){1'b0}}, gain_reg};
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.gain      = gain_reg;

endmodule

>>> design/cdm_deadband.sv
// ----------------------------------------------------------------------------
// cdm_deadband
// three stage deadband with threshold removal and rounded rescale
// ----------------------------------------------------------------------------
module cdm_deadband
(
    input  logic                            clk,
    input  logic                            en,
    input  cdm_pkg::cdm_cfg_t               cfg,
    input  logic signed [cdm_pkg::IN_W-1:0] din,
    output logic signed [cdm_pkg::DB_W-1:0] dout
);
    import cdm_pkg::*;

    // stage 1: magnitude, compare, subtract
    logic [16:0] abs_val;
    logic        over_next;
    logic [15:0] diff_next;
    logic        over1_reg;
    logic        neg1_reg;
    logic [15:0] diff1_reg;

    // stage 2: product
    logic        over2_reg;
    logic        neg2_reg;
    logic [31:0] prod2_reg;

    // stage 3: round, saturate, sign
    logic [17:0]         rnd;
    logic [16:0]         mag_sat;
    logic signed [DB_W-1:0] dout_next;
    logic signed [DB_W-1:0] dout_reg;

    always_comb
    begin
        abs_val   = din[IN_W-1] ? 17'(-{din[IN_W-1], din}) : {1'b0, din};
        over_next = abs_val > {3'b000, cfg.threshold};
        diff_next = 16'(abs_val - {3'b000, cfg.threshold});
    end

    always_comb
    begin
        rnd     = 18'((33'(prod2_reg) + 33'd16384) >> 15);
        mag_sat = (rnd > 18'(Q15_ONE)) ? {1'b0, Q15_ONE} : rnd[16:0];
        if (!over2_reg)
            dout_next = '0;
        else if (neg2_reg)
            dout_next = -signed'(mag_sat);
        else
            dout_next = signed'(mag_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            over1_reg <= over_next;
            neg1_reg  <= din[IN_W-1];
            diff1_reg <= diff_next;
            over2_reg <= over1_reg;
            neg2_reg  <= neg1_reg;
            prod2_reg <= diff1_reg * cfg.gain;
            dout_reg  <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> design/cdm_sine_shape.sv
// ----------------------------------------------------------------------------
// cdm_sine_shape
// five stage sin(pi/4 * x) with quarter-wave rom and linear interpolation
// ----------------------------------------------------------------------------
module cdm_sine_shape
(
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [cdm_pkg::DB_W-1:0] din,
    output logic signed [cdm_pkg::DB_W-1:0] dout
);
    import cdm_pkg::*;

    localparam sine_tab_t SINE_ROM = build_sine_table();

    // stage 1: magnitude, clamp, table position
    logic [17:0]           v_ext;
    logic [17:0]           v_abs;
    logic [15:0]           m;
    logic [SINE_POS_W-1:0] pos;
    logic [SINE_IDX_W-1:0] idx_raw;
    logic [SINE_IDX_W-1:0] idx_next;
    logic [SINE_IDX_W-1:0] idx1_reg;
    logic [15:0]           frac1_reg;
    logic                  neg1_reg;

    // stage 2: rom read
    logic [SINE_IDX_W-1:0] idx_p1;
    logic [15:0]           a2_reg;
    logic [15:0]           b2_reg;
    logic [15:0]           frac2_reg;
    logic                  neg2_reg;

    // stage 3: slope
    logic [15:0] a3_reg;
    logic [15:0] diff3_reg;
    logic [15:0] frac3_reg;
    logic        neg3_reg;

    // stage 4: slope times fraction
    logic [15:0] a4_reg;
    logic [31:0] prod4_reg;
    logic        neg4_reg;

    // stage 5: interpolate and sign
    logic [16:0]            r;
    logic signed [DB_W-1:0] dout_next;
    logic signed [DB_W-1:0] dout_reg;

    always_comb
    begin
        v_ext    = {din[DB_W-1], din};
        v_abs    = din[DB_W-1] ? -v_ext : v_ext;
        m        = (v_abs > 18'(Q15_ONE)) ? Q15_ONE : v_abs[15:0];
        pos      = SINE_POS_W'(m) * SINE_POS_W'(SINE_TABLE_ENTRIES);
        idx_raw  = pos[SINE_POS_W-1:16];
        idx_next = (idx_raw >= SINE_IDX_W'(SINE_TABLE_ENTRIES)) ?
                   SINE_IDX_W'(SINE_TABLE_ENTRIES - 1) : idx_raw;
        idx_p1   = idx1_reg + 1'b1;
    end

    always_comb
    begin
        r = {1'b0, a4_reg} + 17'((33'(prod4_reg) + 33'd32768) >> 16);
        if (neg4_reg)
            dout_next = -signed'(r);
        else
            dout_next = signed'(r);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg  <= idx_next;
            frac1_reg <= pos[15:0];
            neg1_reg  <= din[DB_W-1];

            a2_reg    <= SINE_ROM[idx1_reg];
            b2_reg    <= SINE_ROM[idx_p1];
            frac2_reg <= frac1_reg;
            neg2_reg  <= neg1_reg;

            a3_reg    <= a2_reg;
            diff3_reg <= (b2_reg >= a2_reg) ? b2_reg - a2_reg : 16'd0;
            frac3_reg <= frac2_reg;
            neg3_reg  <= neg2_reg;

            a4_reg    <= a3_reg;
            prod4_reg <= diff3_reg * frac3_reg;
            neg4_reg  <= neg3_reg;

            dout_reg  <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> design/curvature_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// curvature_drive_mixer_top
// curvature drive mixer: deadband, double sine shaping, throttle scaling, mix
// ----------------------------------------------------------------------------
// pipeline: input transfer to output valid passes 3 deadband stages,
//   2 x 5 sine shaping, 2 throttle scaling and 1 output mix register
// throughput: one transfer per cycle; the whole pipe advances together and
//   holds only while the output register is full and m_axis_tready is low
// reset: rst_n clears all valid bits and loads the config registers with
//   threshold 2458 and gain 35425; the sine roms are constant, no fill pass
module curvature_drive_mixer_top
(
    input  logic                           clk,
    input  logic                           rst_n,

    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // throttle[15:0], steer[31:16]
    input  logic [0:0]                     s_axis_tuser,  // quick_turn[0]

    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // left_drive[16:0],
                                                          // right_drive[33:17], zero[39:34]

    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cdm_pkg::*;

    // number of stages the throttle and raw turn wait for the sine shapers
    localparam int SHAPE_DLY = 2 * SHAPE_LAT;
    localparam int QUICK_DLY = DB_LAT + SHAPE_DLY;

    cdm_cfg_t cfg;

    // global advance: the pipe moves unless the output register is stuck
    logic adv;
    logic vld_reg [0:LATENCY-1];

    // deadband outputs (end of stage 3)
    logic signed [DB_W-1:0] thr_db;
    logic signed [DB_W-1:0] steer_db;

    // shaper chain
    logic signed [DB_W-1:0] shape1;
    logic signed [DB_W-1:0] shape2;

    // side delay lines matching the shapers; the quick turn line also spans the deadband
    logic signed [DB_W-1:0] t_dly_reg [0:SHAPE_DLY-1];
    logic signed [DB_W-1:0] w_dly_reg [0:SHAPE_DLY-1];
    logic                   q_dly_reg [0:QUICK_DLY-1];

    // throttle scaling stage 1: |s| * |t|
    logic [15:0]            s_mag;
    logic [15:0]            t_mag;
    logic [31:0]            prod14_reg;
    logic                   sneg14_reg;
    logic signed [DB_W-1:0] t14_reg;
    logic signed [DB_W-1:0] w14_reg;
    logic                   q14_reg;

    // throttle scaling stage 2: round, sign, quick turn select
    logic [16:0]            p_mag;
    logic signed [17:0]     turn_next;
    logic signed [17:0]     turn15_reg;
    logic signed [DB_W-1:0] t15_reg;

    // output mix with saturation
    logic signed [18:0]      sum_l;
    logic signed [18:0]      sum_r;
    logic signed [OUT_W-1:0] left_next;
    logic signed [OUT_W-1:0] right_next;
    logic signed [OUT_W-1:0] left_reg;
    logic signed [OUT_W-1:0] right_reg;

    // ------------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------------
    cdm_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------------
    // handshake and valid tracking
    // ------------------------------------------------------------------------
    assign adv           = !vld_reg[LATENCY-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < LATENCY; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ------------------------------------------------------------------------
    // deadband on both commands
    // ------------------------------------------------------------------------
    cdm_deadband u_db_throttle
    (
        .clk  (clk),
        .en   (adv),
        .cfg  (cfg),
        .din  (signed'(s_axis_tdata[15:0])),
        .dout (thr_db)
    );

    cdm_deadband u_db_steer
    (
        .clk  (clk),
        .en   (adv),
        .cfg  (cfg),
        .din  (signed'(s_axis_tdata[31:16])),
        .dout (steer_db)
    );

    // ------------------------------------------------------------------------
    // sine shaping, applied twice
    // ------------------------------------------------------------------------
    cdm_sine_shape u_shape1
    (
        .clk  (clk),
        .en   (adv),
        .din  (steer_db),
        .dout (shape1)
    );

    cdm_sine_shape u_shape2
    (
        .clk  (clk),
        .en   (adv),
        .din  (shape1),
        .dout (shape2)
    );

    // ------------------------------------------------------------------------
    // delay lines, throttle scaling and output mix
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_mag = shape2[DB_W-1] ? 16'(-shape2) : shape2[15:0];
        t_mag = t_dly_reg[SHAPE_DLY-1][DB_W-1] ?
                16'(-t_dly_reg[SHAPE_DLY-1]) : t_dly_reg[SHAPE_DLY-1][15:0];
    end

    // 2 * p rounded at bit 15 equals p rounded at bit 14
    always_comb
    begin
        p_mag = 17'((33'(prod14_reg) + 33'd8192) >> 14);
        if (q14_reg)
            turn_next = 18'(w14_reg);
        else if (sneg14_reg)
            turn_next = -signed'({1'b0, p_mag});
        else
            turn_next = signed'({1'b0, p_mag});
    end

    always_comb
    begin
        sum_l = 19'(t15_reg) + 19'(turn15_reg);
        sum_r = 19'(t15_reg) - 19'(turn15_reg);
        if (sum_l > 19'sd65535)
            left_next = 17'sd65535;
        else if (sum_l < -19'sd65536)
            left_next = -17'sd65536;
        else
            left_next = sum_l[OUT_W-1:0];
        if (sum_r > 19'sd65535)
            right_next = 17'sd65535;
        else if (sum_r < -19'sd65536)
            right_next = -17'sd65536;
        else
            right_next = sum_r[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // quick turn flag rides along from the input transfer
            q_dly_reg[0] <= s_axis_tuser[0];
            for (int i = 1; i < QUICK_DLY; i++)
                q_dly_reg[i] <= q_dly_reg[i-1];

            // throttle and raw turn wait out the shapers
            t_dly_reg[0] <= thr_db;
            w_dly_reg[0] <= steer_db;
            for (int i = 1; i < SHAPE_DLY; i++)
            begin
                t_dly_reg[i] <= t_dly_reg[i-1];
                w_dly_reg[i] <= w_dly_reg[i-1];
            end

            prod14_reg <= s_mag * t_mag;
            sneg14_reg <= shape2[DB_W-1];
            t14_reg    <= t_dly_reg[SHAPE_DLY-1];
            w14_reg    <= w_dly_reg[SHAPE_DLY-1];
            q14_reg    <= q_dly_reg[QUICK_DLY-1];

            turn15_reg <= turn_next;
            t15_reg    <= t14_reg;

            left_reg   <= left_next;
            right_reg  <= right_next;
        end
    end

    assign m_axis_tdata = {6'b000000, right_reg, left_reg};

endmodule
